FILE: src/rws_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rws_pkg
// Shared widths, codes and defaults of the roulette wheel selection engine.
// ----------------------------------------------------------------------------
package rws_pkg;

   localparam int DEFAULT_MAX_POP = 256;

   localparam int OPCODE_W  = 1;
   localparam int SLOT_W    = 8;
   localparam int FITNESS_W = 32;
   localparam int FRAC_W    = 16;
   localparam int WEIGHT_W  = 32;
   localparam int TOTAL_W   = 40;
   localparam int POP_W     = 9;

   localparam logic [OPCODE_W-1:0] OP_LOAD = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_SPIN = 1'b1;

endpackage : rws_pkg
`default_nettype wire

FILE: src/rws_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rws channel interfaces
// Valid/ready channels for request beats, response beats and the csr write.
// ----------------------------------------------------------------------------
interface rws_req_if;
   logic                                   valid;
   logic                                   ready;
   logic        [rws_pkg::OPCODE_W-1:0]    opcode;
   logic        [rws_pkg::SLOT_W-1:0]      slot_index;
   logic signed [rws_pkg::FITNESS_W-1:0]   fitness_value;
   logic        [rws_pkg::FRAC_W-1:0]      random_fraction;

   modport source (output valid, opcode, slot_index, fitness_value, random_fraction,
                   input ready);
   modport sink   (input valid, opcode, slot_index, fitness_value, random_fraction,
                   output ready);
endinterface : rws_req_if

interface rws_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rws_pkg::SLOT_W-1:0]    selected_index;
   logic [rws_pkg::TOTAL_W-1:0]   total_weight;

   modport source (output valid, selected_index, total_weight, input ready);
   modport sink   (input valid, selected_index, total_weight, output ready);
endinterface : rws_rsp_if

interface rws_csr_if;
   logic                        valid;
   logic                        ready;
   logic [rws_pkg::POP_W-1:0]   pop_size;

   modport source (output valid, pop_size, input ready);
   modport sink   (input valid, pop_size, output ready);
endinterface : rws_csr_if
`default_nettype wire

FILE: src/roulette_wheel_select_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// roulette_wheel_select_core
// Fitness-proportional selection. A load beat stores the negated fitness,
// clamped at zero, as the slot's weight and updates the running total; it
// passes through the load state and gives no response. A spin beat forms the
// threshold (total * fraction) >> 16 and walks the stored weights one memory
// read per cycle, returning the first slot whose running sum reaches the
// threshold (or the last slot in use). The walk reads one weight at a time,
// as the weight memory has a single read port. After reset the weight memory
// is swept to zero, one entry per cycle; no request beat is taken meanwhile,
// csr writes are.
// ----------------------------------------------------------------------------
module roulette_wheel_select_core #(
   parameter int MAX_POP = rws_pkg::DEFAULT_MAX_POP
) (
   input  wire logic  clock,
   input  wire logic  reset,
   rws_req_if.sink    req_if,
   rws_rsp_if.source  rsp_if,
   rws_csr_if.sink    csr_if
);

   localparam int AW   = (MAX_POP > 1) ? $clog2(MAX_POP) : 1;
   localparam int SW   = rws_pkg::WEIGHT_W + AW;
   localparam int CW   = (SW > rws_pkg::TOTAL_W) ? SW : rws_pkg::TOTAL_W;
   localparam int PW   = (rws_pkg::POP_W > AW + 1) ? rws_pkg::POP_W : AW + 1;
   localparam int MW   = rws_pkg::TOTAL_W + rws_pkg::FRAC_W;
   localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_POP - 1);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_LOAD  = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   logic [rws_pkg::WEIGHT_W-1:0] weight_mem [MAX_POP];

   state_type                       state_ff, state_in;
   logic [AW-1:0]                   clr_idx_ff, clr_idx_in;
   logic [rws_pkg::POP_W-1:0]       pop_ff, pop_in;
   logic [rws_pkg::TOTAL_W-1:0]     total_ff, total_in;
   logic [rws_pkg::WEIGHT_W-1:0]    wr_weight_ff, wr_weight_in;
   logic [AW-1:0]                   wr_addr_ff, wr_addr_in;
   logic [rws_pkg::TOTAL_W-1:0]     thr_ff, thr_in;
   logic [AW-1:0]                   last_ff, last_in;
   logic [AW-1:0]                   addr_ff, addr_in;
   logic                            issue_ff, issue_in;
   logic                            pend_ff, pend_in;
   logic [AW-1:0]                   pend_idx_ff, pend_idx_in;
   logic [SW-1:0]                   sum_ff, sum_in;
   logic [AW-1:0]                   pick_ff, pick_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [rws_pkg::SLOT_W-1:0]      rsp_index_ff, rsp_index_in;
   logic [rws_pkg::TOTAL_W-1:0]     rsp_total_ff, rsp_total_in;
   logic [rws_pkg::WEIGHT_W-1:0]    rd_data_ff;

   logic                            mem_we;
   logic [AW-1:0]                   mem_waddr;
   logic [rws_pkg::WEIGHT_W-1:0]    mem_wdata;
   logic [AW-1:0]                   mem_raddr;

   logic                            req_fire;
   logic                            rsp_free;
   logic                            load_ok;
   logic [rws_pkg::WEIGHT_W-1:0]    new_weight;
   logic [MW-1:0]                   product;
   logic [PW-1:0]                   pop_ext;
   logic [AW-1:0]                   last_slot;
   logic [SW-1:0]                   sum_next;
   logic                            hit;

   assign req_fire   = req_if.valid && req_if.ready;
   assign rsp_free   = !rsp_valid_ff || rsp_if.ready;
   assign load_ok    = 32'(req_if.slot_index) < 32'(MAX_POP);
   assign new_weight = req_if.fitness_value[rws_pkg::FITNESS_W-1]
                       ? (32'd0 - unsigned'(req_if.fitness_value)) : '0;
   assign product    = MW'(total_ff) * MW'(req_if.random_fraction);
   assign sum_next   = sum_ff + SW'(rd_data_ff);
   assign hit        = CW'(sum_next) >= CW'(thr_ff);
   assign pop_ext    = PW'(pop_ff);

   // pop_size of zero acts as one, above MAX_POP acts as MAX_POP
   always_comb begin
      if (pop_ff == '0) begin
         last_slot = '0;
      end else if (pop_ext > PW'(MAX_POP)) begin
         last_slot = LAST_SLOT;
      end else begin
         last_slot = AW'(pop_ext - PW'(1));
      end
   end

   assign req_if.ready = (state_ff == ST_IDLE);
   assign csr_if.ready = 1'b1;

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.selected_index = rsp_index_ff;
   assign rsp_if.total_weight   = rsp_total_ff;

   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      pop_in       = (csr_if.valid && csr_if.ready) ? csr_if.pop_size : pop_ff;
      total_in     = total_ff;
      wr_weight_in = wr_weight_ff;
      wr_addr_in   = wr_addr_ff;
      thr_in       = thr_ff;
      last_in      = last_ff;
      addr_in      = addr_ff;
      issue_in     = issue_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      sum_in       = sum_ff;
      pick_in      = pick_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_index_in = rsp_index_ff;
      rsp_total_in = rsp_total_ff;
      mem_we       = 1'b0;
      mem_waddr    = wr_addr_ff;
      mem_wdata    = wr_weight_ff;
      mem_raddr    = addr_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_ff;
            mem_wdata = '0;
            if (clr_idx_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end else begin
               clr_idx_in = clr_idx_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            // read the old weight of the addressed slot right away
            mem_raddr = AW'(req_if.slot_index);
            if (req_fire) begin
               if (req_if.opcode == rws_pkg::OP_SPIN) begin
                  thr_in   = product[MW-1:rws_pkg::FRAC_W];
                  last_in  = last_slot;
                  addr_in  = '0;
                  issue_in = 1'b1;
                  pend_in  = 1'b0;
                  sum_in   = '0;
                  state_in = ST_SCAN;
               end else if (load_ok) begin
                  wr_weight_in = new_weight;
                  wr_addr_in   = AW'(req_if.slot_index);
                  state_in     = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            mem_we   = 1'b1;
            total_in = total_ff - rws_pkg::TOTAL_W'(rd_data_ff)
                       + rws_pkg::TOTAL_W'(wr_weight_ff);
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            // each read is registered and accumulated in the cycle after it is issued
            pend_in = issue_ff;
            if (issue_ff) begin
               pend_idx_in = addr_ff;
               if (addr_ff == last_ff) begin
                  issue_in = 1'b0;
               end else begin
                  addr_in = addr_ff + AW'(1);
               end
            end
            if (pend_ff) begin
               sum_in = sum_next;
               if (hit || pend_idx_ff == last_ff) begin
                  pick_in  = hit ? pend_idx_ff : last_ff;
                  issue_in = 1'b0;
                  pend_in  = 1'b0;
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = rws_pkg::SLOT_W'(pick_ff);
               rsp_total_in = total_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         pop_ff       <= rws_pkg::POP_W'(1);
         total_ff     <= '0;
         issue_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         pop_ff       <= pop_in;
         total_ff     <= total_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_weight_ff <= wr_weight_in;
      wr_addr_ff   <= wr_addr_in;
      thr_ff       <= thr_in;
      last_ff      <= last_in;
      addr_ff      <= addr_in;
      pend_idx_ff  <= pend_idx_in;
      sum_ff       <= sum_in;
      pick_ff      <= pick_in;
      rsp_index_ff <= rsp_index_in;
      rsp_total_ff <= rsp_total_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         weight_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= weight_mem[mem_raddr];
   end

   // threshold is a fraction of the total, which cannot move during a walk
   a_thr_below_total: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (thr_ff <= total_ff))
      else $error("spin threshold above total weight");

   a_pick_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (pick_ff <= last_ff))
      else $error("selected slot beyond active population");

   a_rsp_from_spin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised without a finished spin");

   a_load_writes: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_if.opcode == rws_pkg::OP_LOAD && load_ok)
      |=> (state_ff == ST_LOAD && mem_we))
      else $error("load beat did not reach the weight write");

endmodule : roulette_wheel_select_core
`default_nettype wire
